[src/penalty_contact_force_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the contact force block.
// Both expect a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef PENALTY_CONTACT_FORCE_MACROS_SVH
`define PENALTY_CONTACT_FORCE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Types, constants and fixed-point helpers of the contact force pipeline.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_BITS_MAX = 24;
  localparam int UNIT_W        = FRAC_BITS_MAX + 1;
  localparam int SQ_STEPS      = 32;
  localparam int IN_W          = 344;
  localparam int OUT_W         = 96;
  localparam int CFG_W         = 48;
  localparam int CFG_AW        = 3;

  localparam logic [62:0] WIDE_CAP = 63'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [17:0] FRIC_RST = 18'd39322;
  localparam logic [31:0] STEP_RST = 32'd4294967;
  localparam logic [31:0] SLIP_RST = 32'd7;

  typedef enum logic [CFG_AW-1:0] {
    CFG_NORMAL_STIFF = 3'd0,
    CFG_TANG_STIFF   = 3'd1,
    CFG_NORMAL_DAMP  = 3'd2,
    CFG_TANG_DAMP    = 3'd3,
    CFG_FRICTION     = 3'd4,
    CFG_TIME_STEP    = 3'd5,
    CFG_SLIP         = 3'd6
  } cfg_idx_t;

  // Two partial products of a 64 by 32 bit multiplication.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } mp_t;

  function automatic mp_t mul_split(input logic [63:0] a, input logic [31:0] b);
    mp_t p;
    p.lo = 64'(a[31:0]) * 64'(b);
    p.hi = 64'(a[63:32]) * 64'(b);
    return p;
  endfunction

  // Joins the partial products, shifts right and saturates at WIDE_CAP.
  function automatic logic [62:0] mul_fin(input mp_t p, input int unsigned sh);
    logic [127:0] full;
    logic [127:0] sft;
    full = 128'(p.lo) + (128'(p.hi) << 32);
    sft  = full >> sh;
    if (sft > 128'(WIDE_CAP)) begin
      return WIDE_CAP;
    end
    return sft[62:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

endpackage

[src/penalty_contact_force.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; the square
// root, the effective mass divide and the slip direction divides are unrolled
// one step per pipeline stage.
// A stall at the output freezes the whole pipeline in place.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// penalty_contact_force
// Spring-dashpot contact force with Coulomb friction, one contact per item.
// ----------------------------------------------------------------------------
module penalty_contact_force #(
  parameter int FRAC_BITS = pcf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pcf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pcf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // normal_x, normal_y, normal_z, vel_first_x/y/z, vel_second_x/y/z,
  // overlap, mass_first, mass_second, two zero bits
  input  logic [pcf_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // force_x, force_y, force_z
  output logic [pcf_pkg::OUT_W-1:0]  out_tdata
);
  import pcf_pkg::*;

`include "penalty_contact_force_macros.svh"

  localparam int NC = FRAC_BITS + 1;
  localparam int NA = 7;
  localparam int ND = 10;

  typedef struct packed {
    logic [2:0][32:0] rv;
    logic [2:0][17:0] n;
    logic [31:0]      dl;
    logic [63:0]      mp;
    logic [32:0]      ms;
    logic [2:0][50:0] pr;
    logic [31:0]      vn;
    logic [2:0][31:0] vt;
    logic [2:0][63:0] sqv;
    logic [63:0]      sq;
  } ast_t;

  typedef struct packed {
    logic [63:0]      x;
    logic [34:0]      srem;
    logic [31:0]      root;
    logic [63:0]      dq;
    logic [33:0]      drem;
    logic [31:0]      quo;
    logic [32:0]      ms;
    logic [2:0][31:0] vt;
    logic [2:0][17:0] n;
    logic [31:0]      vn;
    logic [31:0]      dl;
  } bst_t;

  typedef struct packed {
    logic [2:0][32:0]       rem;
    logic [2:0][UNIT_W-1:0] q;
    logic [2:0]             lsb;
    logic [31:0]            vtm;
    logic [31:0]            eff;
    logic [31:0]            vn;
    logic [31:0]            dl;
    logic [2:0][17:0]       n;
    logic [2:0]             vneg;
    logic                   slip;
  } cst_t;

  typedef struct packed {
    logic [31:0]            eff;
    logic [31:0]            vtm;
    logic [31:0]            vn;
    logic [31:0]            dl;
    logic [2:0][17:0]       n;
    logic [2:0]             vneg;
    logic                   slip;
    logic [2:0][UNIT_W-1:0] u;
    mp_t [3:0]              pp;
    logic [62:0]            gn;
    logic [62:0]            gt;
    logic [62:0]            knd;
    logic [31:0]            dtv;
    logic [62:0]            gnv;
    logic [62:0]            fta;
    logic [62:0]            ftb;
    logic [63:0]            fn;
    logic [62:0]            ft;
    logic [62:0]            capf;
    logic [2:0][62:0]       fnm;
    logic [2:0][63:0]       fni;
    logic [2:0][62:0]       term;
  } dst_t;

  logic        en;
  logic [47:0] kn_r, kt_r, gnd_r, gtd_r;
  logic [17:0] mu_r;
  logic [31:0] dt_r, slip_r;

  ast_t a_r   [NA];
  ast_t a_nxt [NA];
  logic a_v_r [NA];

  bst_t b_init;
  bst_t b_in  [SQ_STEPS];
  bst_t b_r   [SQ_STEPS];
  logic bv_in [SQ_STEPS];
  logic bv_r  [SQ_STEPS];

  cst_t c_init;
  cst_t c_in  [NC];
  cst_t c_r   [NC];
  logic cv_in [NC];
  logic cv_r  [NC];

  dst_t d_r   [ND];
  dst_t d_nxt [ND];
  logic d_v_r [ND];

  logic [OUT_W-1:0] out_r, out_nxt;
  logic             out_valid_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kn_r   <= '0;
      kt_r   <= '0;
      gnd_r  <= '0;
      gtd_r  <= '0;
      mu_r   <= FRIC_RST;
      dt_r   <= STEP_RST;
      slip_r <= SLIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_NORMAL_STIFF: kn_r   <= cfg_wdata;
        CFG_TANG_STIFF:   kt_r   <= cfg_wdata;
        CFG_NORMAL_DAMP:  gnd_r  <= cfg_wdata;
        CFG_TANG_DAMP:    gtd_r  <= cfg_wdata;
        CFG_FRICTION:     mu_r   <= cfg_wdata[17:0];
        CFG_TIME_STEP:    dt_r   <= cfg_wdata[31:0];
        CFG_SLIP:         slip_r <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // Front stages: relative velocity, normal speed, tangential vector, sum of squares.
  logic signed [52:0] a_dot, a_val;
  logic        [52:0] a_dmag;
  logic signed [52:0] a_rvn, a_diff;
  logic        [50:0] a_pmag;
  logic        [31:0] a_vm;

  always_comb begin
    a_nxt[0] = '0;
    for (int i = 0; i < 3; i++) begin
      a_nxt[0].n[i]  = in_tdata[18*i +: 18];
      a_nxt[0].rv[i] = 33'($signed(in_tdata[150 + 32*i +: 32]))
                     - 33'($signed(in_tdata[54 + 32*i +: 32]));
    end
    a_nxt[0].dl = in_tdata[246 +: 32];
    a_nxt[0].mp = 64'(in_tdata[278 +: 32]) * 64'(in_tdata[310 +: 32]);
    a_nxt[0].ms = 33'(in_tdata[278 +: 32]) + 33'(in_tdata[310 +: 32]);

    a_nxt[1] = a_r[0];
    for (int i = 0; i < 3; i++) begin
      a_nxt[1].pr[i] = $signed(a_r[0].rv[i]) * $signed(a_r[0].n[i]);
    end

    a_nxt[2] = a_r[1];
    a_dot  = 53'($signed(a_r[1].pr[0])) + 53'($signed(a_r[1].pr[1]))
           + 53'($signed(a_r[1].pr[2]));
    a_dmag = a_dot[52] ? 53'(-a_dot) : 53'(a_dot);
    a_dmag = a_dmag >> FRAC_BITS;
    a_val  = a_dot[52] ? -$signed(a_dmag) : $signed(a_dmag);
    a_nxt[2].vn = sat32(64'(a_val));

    a_nxt[3] = a_r[2];
    for (int i = 0; i < 3; i++) begin
      a_nxt[3].pr[i] = $signed(a_r[2].vn) * $signed(a_r[2].n[i]);
    end

    a_nxt[4] = a_r[3];
    for (int i = 0; i < 3; i++) begin
      a_pmag = a_r[3].pr[i][50] ? 51'(-a_r[3].pr[i]) : a_r[3].pr[i];
      a_pmag = a_pmag >> FRAC_BITS;
      a_rvn  = a_r[3].pr[i][50] ? -$signed(53'(a_pmag)) : $signed(53'(a_pmag));
      a_diff = 53'($signed(a_r[3].rv[i])) - a_rvn;
      a_nxt[4].vt[i] = sat32(64'(a_diff));
    end

    a_nxt[5] = a_r[4];
    for (int i = 0; i < 3; i++) begin
      a_vm = mag32(a_r[4].vt[i]);
      a_nxt[5].sqv[i] = 64'(a_vm) * 64'(a_vm);
    end

    a_nxt[6] = a_r[5];
    a_nxt[6].sq = a_r[5].sqv[0] + a_r[5].sqv[1] + a_r[5].sqv[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NA; k++) begin
        a_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      a_v_r[0] <= in_tvalid;
      for (int k = 1; k < NA; k++) begin
        a_v_r[k] <= a_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NA; k++) begin
        a_r[k] <= a_nxt[k];
      end
    end
  end

  // Square root and effective mass divide, one result bit per stage.
  always_comb begin
    b_init      = '0;
    b_init.x    = a_r[NA-1].sq;
    b_init.dq   = {a_r[NA-1].mp[31:0], 32'b0};
    b_init.drem = {2'b00, a_r[NA-1].mp[63:32]};
    b_init.ms   = a_r[NA-1].ms;
    b_init.vt   = a_r[NA-1].vt;
    b_init.n    = a_r[NA-1].n;
    b_init.vn   = a_r[NA-1].vn;
    b_init.dl   = a_r[NA-1].dl;
  end

  assign b_in[0]  = b_init;
  assign bv_in[0] = a_v_r[NA-1];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    bst_t        b_nxt;
    logic [34:0] sr_sh, st;
    logic [33:0] dr_sh;

    if (g > 0) begin : g_link
      assign b_in[g]  = b_r[g-1];
      assign bv_in[g] = bv_r[g-1];
    end

    always_comb begin
      b_nxt = b_in[g];
      sr_sh = {b_in[g].srem[32:0], b_in[g].x[63:62]};
      st    = {1'b0, b_in[g].root, 2'b01};
      if (sr_sh >= st) begin
        b_nxt.srem = sr_sh - st;
        b_nxt.root = {b_in[g].root[30:0], 1'b1};
      end else begin
        b_nxt.srem = sr_sh;
        b_nxt.root = {b_in[g].root[30:0], 1'b0};
      end
      b_nxt.x = {b_in[g].x[61:0], 2'b00};
      dr_sh   = {b_in[g].drem[32:0], b_in[g].dq[63]};
      if (dr_sh >= {1'b0, b_in[g].ms}) begin
        b_nxt.drem = dr_sh - {1'b0, b_in[g].ms};
        b_nxt.quo  = {b_in[g].quo[30:0], 1'b1};
      end else begin
        b_nxt.drem = dr_sh;
        b_nxt.quo  = {b_in[g].quo[30:0], 1'b0};
      end
      b_nxt.dq = {b_in[g].dq[62:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bv_r[g] <= 1'b0;
      end else if (en) begin
        bv_r[g] <= bv_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_r[g] <= b_nxt;
      end
    end
  end

  // Slip direction divides, one quotient bit per stage.
  logic [31:0] c_vm;

  always_comb begin
    c_init      = '0;
    c_init.vtm  = b_r[SQ_STEPS-1].root;
    c_init.eff  = (b_r[SQ_STEPS-1].ms == '0) ? '0 : b_r[SQ_STEPS-1].quo;
    c_init.vn   = b_r[SQ_STEPS-1].vn;
    c_init.dl   = b_r[SQ_STEPS-1].dl;
    c_init.n    = b_r[SQ_STEPS-1].n;
    c_init.slip = (b_r[SQ_STEPS-1].root != '0) && (b_r[SQ_STEPS-1].root >= slip_r);
    for (int i = 0; i < 3; i++) begin
      c_vm             = mag32(b_r[SQ_STEPS-1].vt[i]);
      c_init.vneg[i]   = b_r[SQ_STEPS-1].vt[i][31];
      c_init.rem[i]    = {2'b00, c_vm[31:1]};
      c_init.lsb[i]    = c_vm[0];
    end
  end

  assign c_in[0]  = c_init;
  assign cv_in[0] = bv_r[SQ_STEPS-1];

  for (genvar g = 0; g < NC; g++) begin : g_unit
    cst_t        c_nxt;
    logic [32:0] r_sh;

    if (g > 0) begin : g_link
      assign c_in[g]  = c_r[g-1];
      assign cv_in[g] = cv_r[g-1];
    end

    always_comb begin
      c_nxt = c_in[g];
      for (int i = 0; i < 3; i++) begin
        r_sh = {c_in[g].rem[i][31:0], (g == 0) ? c_in[g].lsb[i] : 1'b0};
        if (r_sh >= {1'b0, c_in[g].vtm}) begin
          c_nxt.rem[i] = r_sh - {1'b0, c_in[g].vtm};
          c_nxt.q[i]   = {c_in[g].q[i][UNIT_W-2:0], 1'b1};
        end else begin
          c_nxt.rem[i] = r_sh;
          c_nxt.q[i]   = {c_in[g].q[i][UNIT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[g] <= 1'b0;
      end else if (en) begin
        cv_r[g] <= cv_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[g] <= c_nxt;
      end
    end
  end

  // Force stages: a multiply stage is always followed by a join-and-saturate stage.
  logic signed [63:0] d_t1, d_t2, d_fn, d_sub;
  logic        [63:0] d_ftsum;
  logic        [62:0] d_fm;

  always_comb begin
    d_nxt[0]      = '0;
    d_nxt[0].eff  = c_r[NC-1].eff;
    d_nxt[0].vtm  = c_r[NC-1].vtm;
    d_nxt[0].vn   = c_r[NC-1].vn;
    d_nxt[0].dl   = c_r[NC-1].dl;
    d_nxt[0].n    = c_r[NC-1].n;
    d_nxt[0].vneg = c_r[NC-1].vneg;
    d_nxt[0].slip = c_r[NC-1].slip;
    d_nxt[0].u    = c_r[NC-1].q;
    d_nxt[0].pp[0] = mul_split({16'b0, gnd_r}, c_r[NC-1].eff);
    d_nxt[0].pp[1] = mul_split({16'b0, gtd_r}, c_r[NC-1].eff);
    d_nxt[0].pp[2] = mul_split({16'b0, kn_r}, mag32(c_r[NC-1].dl));
    d_nxt[0].pp[3] = mul_split({32'b0, dt_r}, c_r[NC-1].vtm);

    d_nxt[1]     = d_r[0];
    d_nxt[1].gn  = mul_fin(d_r[0].pp[0], FRAC_BITS);
    d_nxt[1].gt  = mul_fin(d_r[0].pp[1], FRAC_BITS);
    d_nxt[1].knd = mul_fin(d_r[0].pp[2], FRAC_BITS);
    d_nxt[1].dtv = 32'(mul_fin(d_r[0].pp[3], 32));

    d_nxt[2]       = d_r[1];
    d_nxt[2].pp[0] = mul_split({1'b0, d_r[1].gn}, mag32(d_r[1].vn));
    d_nxt[2].pp[1] = mul_split({16'b0, kt_r}, d_r[1].dtv);
    d_nxt[2].pp[2] = mul_split({1'b0, d_r[1].gt}, d_r[1].vtm);

    d_nxt[3]     = d_r[2];
    d_nxt[3].gnv = mul_fin(d_r[2].pp[0], FRAC_BITS);
    d_nxt[3].fta = mul_fin(d_r[2].pp[1], FRAC_BITS);
    d_nxt[3].ftb = mul_fin(d_r[2].pp[2], FRAC_BITS);

    d_nxt[4] = d_r[3];
    d_t1 = d_r[3].dl[31] ? -$signed({1'b0, d_r[3].knd}) : $signed({1'b0, d_r[3].knd});
    d_t2 = d_r[3].vn[31] ? -$signed({1'b0, d_r[3].gnv}) : $signed({1'b0, d_r[3].gnv});
    d_fn = d_t1 - d_t2;
    if (d_fn > $signed({1'b0, WIDE_CAP})) begin
      d_nxt[4].fn = {1'b0, WIDE_CAP};
    end else if (d_fn < -$signed({1'b0, WIDE_CAP})) begin
      d_nxt[4].fn = -$signed({1'b0, WIDE_CAP});
    end else begin
      d_nxt[4].fn = d_fn;
    end
    d_ftsum = 64'(d_r[3].fta) + 64'(d_r[3].ftb);
    d_nxt[4].ft = (d_ftsum > 64'(WIDE_CAP)) ? WIDE_CAP : d_ftsum[62:0];

    d_nxt[5] = d_r[4];
    d_fm = d_r[4].fn[63] ? 63'(-d_r[4].fn) : d_r[4].fn[62:0];
    d_nxt[5].pp[0] = mul_split({1'b0, d_fm}, {14'b0, mu_r});
    for (int i = 0; i < 3; i++) begin
      d_nxt[5].pp[i+1] = mul_split({1'b0, d_fm},
        {14'b0, d_r[4].n[i][17] ? 18'(-d_r[4].n[i]) : d_r[4].n[i]});
    end

    d_nxt[6]      = d_r[5];
    d_nxt[6].capf = mul_fin(d_r[5].pp[0], FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      d_nxt[6].fnm[i] = mul_fin(d_r[5].pp[i+1], FRAC_BITS);
    end

    d_nxt[7]    = d_r[6];
    d_nxt[7].ft = (d_r[6].ft > d_r[6].capf) ? d_r[6].capf : d_r[6].ft;
    for (int i = 0; i < 3; i++) begin
      d_nxt[7].fni[i] = (d_r[6].fn[63] != d_r[6].n[i][17])
                      ? -$signed({1'b0, d_r[6].fnm[i]}) : $signed({1'b0, d_r[6].fnm[i]});
    end

    d_nxt[8] = d_r[7];
    for (int i = 0; i < 3; i++) begin
      d_nxt[8].pp[i] = mul_split({1'b0, d_r[7].ft}, {7'b0, d_r[7].u[i]});
    end

    d_nxt[9] = d_r[8];
    for (int i = 0; i < 3; i++) begin
      d_nxt[9].term[i] = mul_fin(d_r[8].pp[i], FRAC_BITS);
    end

    for (int i = 0; i < 3; i++) begin
      d_sub = '0;
      if (d_r[9].slip) begin
        d_sub = d_r[9].vneg[i] ? -$signed({1'b0, d_r[9].term[i]})
                               : $signed({1'b0, d_r[9].term[i]});
      end
      out_nxt[32*i +: 32] = sat32($signed(d_r[9].fni[i]) - d_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ND; k++) begin
        d_v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      d_v_r[0] <= cv_r[NC-1];
      for (int k = 1; k < ND; k++) begin
        d_v_r[k] <= d_v_r[k-1];
      end
      out_valid_r <= d_v_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ND; k++) begin
        d_r[k] <= d_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  `PCF_ASSERT_NEXT(a_stall_freeze, !en && a_v_r[0], a_v_r[0] && $stable(a_r[0]), "stalled item moved")
  `PCF_ASSERT_SAME(a_sqrt_rem, bv_r[SQ_STEPS-1], b_r[SQ_STEPS-1].srem <= {b_r[SQ_STEPS-1].root, 1'b0}, "square root remainder too large")
  `PCF_ASSERT_SAME(a_div_rem, bv_r[SQ_STEPS-1] && b_r[SQ_STEPS-1].ms != '0, b_r[SQ_STEPS-1].drem < {1'b0, b_r[SQ_STEPS-1].ms}, "mass divide remainder too large")
  `PCF_ASSERT_SAME(a_unit_bound, d_v_r[0] && d_r[0].slip, (d_r[0].u[0] <= (UNIT_W'(1) << FRAC_BITS)) && (d_r[0].u[1] <= (UNIT_W'(1) << FRAC_BITS)) && (d_r[0].u[2] <= (UNIT_W'(1) << FRAC_BITS)), "slip direction above one")

endmodule
